// ===== src/assert_macros.svh =====
// assertion macros shared by the rgb to hsb pixel pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequence holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/rgbhsb_pkg.sv =====
// widths, constants and stage types of the rgb to hsb pixel pipeline
`default_nettype none

package rgbhsb_pkg;

    localparam int CHANNEL_BITS = 8;

    // channel sum and the reciprocal of three used for lightness
    localparam int SUM_W       = CHANNEL_BITS + 2;
    localparam int RECIP_SHIFT = SUM_W + 1;
    localparam int RECIP_W     = RECIP_SHIFT;
    localparam int PROD3_W     = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(((2 ** RECIP_SHIFT) + 2) / 3);

    // hue numerator stays below 6*delta
    localparam int NUM_W = CHANNEL_BITS + 3;

    // divider widths: quotient never exceeds full scale
    localparam int DVD_W = 2 * CHANNEL_BITS + 3;
    localparam int DVR_W = CHANNEL_BITS + 3;
    localparam int QUO_W = CHANNEL_BITS;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] brightness;
        logic [CHANNEL_BITS-1:0] lightness;
    } side_t;

    typedef struct packed {
        logic [DVD_W-1:0] hue_dvd;
        logic [DVR_W-1:0] hue_dvr;
        logic [DVD_W-1:0] sat_dvd;
        logic [DVR_W-1:0] sat_dvr;
        side_t            side;
    } prep_t;

endpackage

`default_nettype wire

// ===== src/rgbhsb_prep.sv =====
// front stages: max/min, sector, hue numerator and divider operands
`default_nettype none
`include "assert_macros.svh"

module rgbhsb_prep (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_vld,
    input  logic [rgbhsb_pkg::CHANNEL_BITS-1:0]  red,
    input  logic [rgbhsb_pkg::CHANNEL_BITS-1:0]  green,
    input  logic [rgbhsb_pkg::CHANNEL_BITS-1:0]  blue,
    output logic                                 out_vld,
    output rgbhsb_pkg::prep_t                    out_data
);
    import rgbhsb_pkg::*;

    localparam int CB  = CHANNEL_BITS;
    localparam int S_W = NUM_W + 1;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    // stage 1
    logic             s1_vld_reg;
    logic [CB-1:0]    s1_r_reg, s1_g_reg, s1_b_reg, s1_hi_reg, s1_lo_reg;
    logic [1:0]       s1_sel_reg;
    logic [SUM_W-1:0] s1_sum_reg;
    logic [CB-1:0]    hi_next, lo_next;
    logic [1:0]       sel_next;
    logic [SUM_W-1:0] sum_next;

    // stage 2
    logic               s2_vld_reg;
    logic [CB-1:0]      s2_delta_reg, s2_hi_reg;
    logic [CB:0]        s2_diff_reg;
    logic [NUM_W-1:0]   s2_base_reg;
    logic [PROD3_W-1:0] s2_prod_reg;
    logic [CB-1:0]      delta_next;
    logic [CB:0]        diff_next;
    logic [NUM_W-1:0]   base_next;
    logic [PROD3_W-1:0] prod_next;

    // stage 3
    logic             s3_vld_reg;
    logic [NUM_W-1:0] s3_num_reg, s3_six_reg;
    logic [CB-1:0]    s3_delta_reg, s3_hi_reg, s3_light_reg;
    logic [S_W-1:0]   num0, num1;
    logic [NUM_W-1:0] num_next, six_next;
    logic             num_ok;

    // stage 4
    logic  out_vld_reg;
    prep_t out_reg;
    prep_t out_next;

    always_comb
    begin
        hi_next = (red > green) ? red : green;
        hi_next = (hi_next > blue) ? hi_next : blue;
        lo_next = (red < green) ? red : green;
        lo_next = (lo_next < blue) ? lo_next : blue;
        // red wins ties, then green
        if (red >= green && red >= blue)
        begin
            sel_next = SEC_RED;
        end
        else if (green >= blue)
        begin
            sel_next = SEC_GREEN;
        end
        else
        begin
            sel_next = SEC_BLUE;
        end
        sum_next = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
    end

    always_comb
    begin
        delta_next = s1_hi_reg - s1_lo_reg;
        unique case (s1_sel_reg)
            SEC_RED:
            begin
                diff_next = {1'b0, s1_g_reg} - {1'b0, s1_b_reg};
                base_next = '0;
            end
            SEC_GREEN:
            begin
                diff_next = {1'b0, s1_b_reg} - {1'b0, s1_r_reg};
                base_next = NUM_W'({delta_next, 1'b0});
            end
            SEC_BLUE:
            begin
                diff_next = {1'b0, s1_r_reg} - {1'b0, s1_g_reg};
                base_next = NUM_W'({delta_next, 2'b00});
            end
            default:
            begin
                diff_next = '0;
                base_next = '0;
            end
        endcase
        prod_next = PROD3_W'(s1_sum_reg) * PROD3_W'(RECIP3);
    end

    always_comb
    begin
        six_next = NUM_W'({s2_delta_reg, 2'b00}) + NUM_W'({s2_delta_reg, 1'b0});
        num0     = {{(S_W-CB-1){s2_diff_reg[CB]}}, s2_diff_reg} + {1'b0, s2_base_reg};
        // negative red sector wraps around the circle
        num1     = num0 + {1'b0, six_next};
        num_next = num0[S_W-1] ? num1[NUM_W-1:0] : num0[NUM_W-1:0];
    end

    always_comb
    begin
        // x*full scale as (x << bits) - x
        out_next.hue_dvd = (DVD_W'(s3_num_reg) << CB) - DVD_W'(s3_num_reg);
        out_next.hue_dvr = DVR_W'(s3_six_reg);
        out_next.sat_dvd = (DVD_W'(s3_delta_reg) << CB) - DVD_W'(s3_delta_reg);
        out_next.sat_dvr = DVR_W'(s3_hi_reg);
        out_next.side.brightness = s3_hi_reg;
        out_next.side.lightness  = s3_light_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= in_vld;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            out_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_r_reg     <= red;
        s1_g_reg     <= green;
        s1_b_reg     <= blue;
        s1_hi_reg    <= hi_next;
        s1_lo_reg    <= lo_next;
        s1_sel_reg   <= sel_next;
        s1_sum_reg   <= sum_next;
        s2_delta_reg <= delta_next;
        s2_diff_reg  <= diff_next;
        s2_base_reg  <= base_next;
        s2_hi_reg    <= s1_hi_reg;
        s2_prod_reg  <= prod_next;
        s3_num_reg   <= num_next;
        s3_six_reg   <= six_next;
        s3_delta_reg <= s2_delta_reg;
        s3_hi_reg    <= s2_hi_reg;
        s3_light_reg <= s2_prod_reg[RECIP_SHIFT +: CB];
        out_reg      <= out_next;
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_reg;

    // gray items have no sector, so only colored ones are bounded
    assign num_ok = (s3_delta_reg == '0) || (s3_num_reg < s3_six_reg);

    `ASSERT_IMPLY(a_hue_num_range, s3_vld_reg, num_ok, "hue numerator not below six times delta")

endmodule

`default_nettype wire

// ===== src/rgbhsb_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
`include "assert_macros.svh"

module rgbhsb_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_vld,
    input  logic [rgbhsb_pkg::DVD_W-1:0]   dividend,
    input  logic [rgbhsb_pkg::DVR_W-1:0]   divisor,
    output logic                           out_vld,
    output logic [rgbhsb_pkg::QUO_W-1:0]   quotient
);
    import rgbhsb_pkg::*;

    localparam int LAST = QUO_W - 1;

    logic             vld_reg  [QUO_W];
    logic             zero_reg [QUO_W];
    logic [DVD_W-1:0] rem_reg  [QUO_W];
    logic [DVR_W-1:0] dvr_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic             rem_ok;

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        logic             vld_in, zero_in, take;
        logic [DVD_W-1:0] rem_in, dvr_sh, rem_next;
        logic [DVR_W-1:0] dvr_in;
        logic [QUO_W-1:0] quo_in, quo_next;

        if (i == 0)
        begin : g_first
            assign vld_in  = in_vld;
            assign zero_in = (divisor == '0);
            assign rem_in  = dividend;
            assign dvr_in  = divisor;
            assign quo_in  = '0;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign zero_in = zero_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign dvr_in  = dvr_reg[i-1];
            assign quo_in  = quo_reg[i-1];
        end

        // quotient is known to fit, so start at its top bit
        assign dvr_sh   = DVD_W'(dvr_in) << (QUO_W - 1 - i);
        assign take     = (rem_in >= dvr_sh);
        assign rem_next = take ? (rem_in - dvr_sh) : rem_in;
        assign quo_next = {quo_in[QUO_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            zero_reg[i] <= zero_in;
            rem_reg[i]  <= rem_next;
            dvr_reg[i]  <= dvr_in;
            quo_reg[i]  <= quo_next;
        end
    end

    assign out_vld  = vld_reg[LAST];
    assign quotient = zero_reg[LAST] ? '0 : quo_reg[LAST];

    assign rem_ok = zero_reg[LAST] || (rem_reg[LAST] < DVD_W'(dvr_reg[LAST]));

    `ASSERT_IMPLY(a_rem_below_dvr, out_vld, rem_ok, "final remainder not below divisor")

endmodule

`default_nettype wire

// ===== src/rgb_to_hsb_pixel.sv =====
// rgb pixel to hue, saturation, brightness and lightness, one item per clock
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | red, green, blue                        | start && !busy
//  result  | hue, saturation, brightness, lightness  | done, one cycle, no back-pressure
//
// one item accepted every cycle; busy is always low
// each item passes through four operand stages,
// then one divider stage per quotient bit in the hue and saturation dividers
// reset clears every valid bit, so no result comes out until an item has gone through
// the receiver cannot stall, so items never wait inside the pipeline
`default_nettype none
`include "assert_macros.svh"

module rgb_to_hsb_pixel (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [rgbhsb_pkg::CHANNEL_BITS-1:0]  red,
    input  logic [rgbhsb_pkg::CHANNEL_BITS-1:0]  green,
    input  logic [rgbhsb_pkg::CHANNEL_BITS-1:0]  blue,
    output logic                                 done,
    output logic [rgbhsb_pkg::CHANNEL_BITS-1:0]  hue,
    output logic [rgbhsb_pkg::CHANNEL_BITS-1:0]  saturation,
    output logic [rgbhsb_pkg::CHANNEL_BITS-1:0]  brightness,
    output logic [rgbhsb_pkg::CHANNEL_BITS-1:0]  lightness
);
    import rgbhsb_pkg::*;

    localparam int LAST = QUO_W - 1;

    logic             in_vld;
    logic             prep_vld;
    prep_t            prep_data;
    logic             hue_vld, sat_vld;
    logic [QUO_W-1:0] hue_q, sat_q;
    side_t            side_reg [QUO_W];

    assign busy   = 1'b0;
    assign in_vld = start && !busy;

    rgbhsb_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_vld),
        .red      (red),
        .green    (green),
        .blue     (blue),
        .out_vld  (prep_vld),
        .out_data (prep_data)
    );

    rgbhsb_div u_hue_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (prep_vld),
        .dividend (prep_data.hue_dvd),
        .divisor  (prep_data.hue_dvr),
        .out_vld  (hue_vld),
        .quotient (hue_q)
    );

    rgbhsb_div u_sat_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (prep_vld),
        .dividend (prep_data.sat_dvd),
        .divisor  (prep_data.sat_dvr),
        .out_vld  (sat_vld),
        .quotient (sat_q)
    );

    // brightness and lightness ride alongside the dividers
    always_ff @(posedge clk)
    begin
        side_reg[0] <= prep_data.side;
        for (int i = 1; i < QUO_W; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign done       = hue_vld;
    assign hue        = hue_q;
    assign saturation = sat_q;
    assign brightness = side_reg[LAST].brightness;
    assign lightness  = side_reg[LAST].lightness;

    `ASSERT_ALWAYS(a_div_aligned, hue_vld == sat_vld, "hue and saturation dividers out of step")
    `ASSERT_IMPLY(a_black_sat, done && brightness == '0, saturation == '0, "black item saturated")
    `ASSERT_IMPLY(a_light_le_bright, done, lightness <= brightness, "lightness above brightness")

endmodule

`default_nettype wire
